[sv/timed_event_heap_queue_core_assert.svh]
// ----------------------------------------------------------------------------
// timed event heap queue assertion macros
// shared property forms for the core checks
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_HEAP_QUEUE_CORE_ASSERT_SVH
`define TIMED_EVENT_HEAP_QUEUE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define TEH_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TEH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/teh_pkg.sv]
// ----------------------------------------------------------------------------
// teh_pkg
// sizes, entry and cell command types, sequencer states for the heap queue
// ----------------------------------------------------------------------------
`default_nettype none

package teh_pkg;

    localparam int IMM_DEPTH  = 16;
    localparam int INT_DEPTH  = 32;
    localparam int MAX_DEPTH  = (IMM_DEPTH > INT_DEPTH) ? IMM_DEPTH : INT_DEPTH;
    localparam int IDX_W      = $clog2(MAX_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int TIME_W     = 32;
    localparam int HND_W      = 16;
    localparam int LATE_W     = 31;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;
    localparam int ADDR_W     = 3;
    localparam int REG_ENABLE = 0;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] tm;
        logic [HND_W-1:0]  hnd;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_a;
        logic [IDX_W-1:0]  rd_b;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        t_entry            wr_data;
        logic              sub_en;
        logic [TIME_W-1:0] amount;
        logic              clamp_en;
    } t_cell_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DONE,
        ST_INS,
        ST_REB,
        ST_LOAD,
        ST_POP_LOAD,
        ST_SIFT,
        ST_FIRE_IMM,
        ST_FIRE_INT,
        ST_END
    } t_state;

endpackage

`default_nettype wire

[sv/teh_cell.sv]
// ----------------------------------------------------------------------------
// teh_cell
// one heap slot: holds a trigger, applies clamp or shift, feeds the read chains
// ----------------------------------------------------------------------------
`default_nettype none

module teh_cell import teh_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_cell_cmd        i_cmd,
    input  wire t_entry           i_chain_a,
    input  wire t_entry           i_chain_b,
    output t_entry                o_chain_a,
    output t_entry                o_chain_b
);

    t_entry r_ent;
    t_entry n_ent;

    always_comb begin
        n_ent = r_ent;
        priority if (i_cmd.wr_en && (i_cmd.wr_idx == i_idx)) begin
            n_ent = i_cmd.wr_data;
        end else if (i_cmd.clamp_en && r_ent.tm[TIME_W-1]) begin
            n_ent.tm = '0;
        end else if (i_cmd.sub_en) begin
            n_ent.tm = r_ent.tm - i_cmd.amount;
        end else begin
            n_ent = r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_chain_a = i_chain_a | ((i_cmd.rd_a == i_idx) ? r_ent : t_entry'('0));
    assign o_chain_b = i_chain_b | ((i_cmd.rd_b == i_idx) ? r_ent : t_entry'('0));

endmodule

`default_nettype wire

[sv/timed_event_heap_queue_core.sv]
// ----------------------------------------------------------------------------
// timed_event_heap_queue_core
// two min-heaps of timed triggers held in rows of cells, with a sift sequencer
// ----------------------------------------------------------------------------
// One item is worked at a time; the input is ready only while the sequencer
// idles. An add walks the sift-up path one heap level at a time, each level
// reading the parent through the cell row's read chain. A tick that fires
// nothing checks the immediate heap, then the internal heap, then ends; each
// fired trigger adds a sift-down walk that refills the root.
// A clock wrap clamps every slot with its top time bit set to zero and then
// rebuilds both heaps, one sift-down walk per inner node; a backwards step
// shifts all slots in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_event_heap_queue_core_assert.svh"

module timed_event_heap_queue_core import teh_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: trigger_time[31:0], handle[47:32], immediate[48], now_time[80:49],
    // context_idle[81], zero pad
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: req_type
    input  wire logic                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata: accepted[0], fired_handle[16:1], fired_immediate[17], lateness[48:18],
    // zero pad
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // tuser: fired
    output logic                       o_m_tuser,
    output logic                       o_m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // input fields
    logic              in_req;
    logic [TIME_W-1:0] in_tm;
    logic [HND_W-1:0]  in_hnd;
    logic              in_imm;
    logic [TIME_W-1:0] in_now;
    logic              in_idle;

    assign in_req  = i_s_tuser;
    assign in_tm   = i_s_tdata[31:0];
    assign in_hnd  = i_s_tdata[47:32];
    assign in_imm  = i_s_tdata[48];
    assign in_now  = i_s_tdata[80:49];
    assign in_idle = i_s_tdata[81];

    // state
    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    logic              r_hsel, n_hsel;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_reb, n_reb;
    t_entry            r_cur, n_cur;
    logic [TIME_W-1:0] r_now, n_now;
    logic              r_idle, n_idle;
    logic              r_acc, n_acc;
    logic [CNT_W-1:0]  r_imm_cnt, n_imm_cnt;
    logic [CNT_W-1:0]  r_int_cnt, n_int_cnt;
    logic [TIME_W-1:0] r_last_time, n_last_time;
    logic              r_enable;
    logic              r_pend_v, n_pend_v;
    logic [HND_W-1:0]  r_pend_hnd, n_pend_hnd;
    logic              r_pend_imm, n_pend_imm;
    logic [LATE_W-1:0] r_pend_late, n_pend_late;

    // output beat register
    logic              r_out_v;
    logic              r_out_acc;
    logic              r_out_fired;
    logic [HND_W-1:0]  r_out_hnd;
    logic              r_out_imm;
    logic [LATE_W-1:0] r_out_late;
    logic              r_out_last;

    logic              out_free;
    logic              out_load;
    logic              out_acc;
    logic              out_fired;
    logic [HND_W-1:0]  out_hnd;
    logic              out_imm;
    logic [LATE_W-1:0] out_late;
    logic              out_last;

    // cell rows
    t_cell_cmd cmd;
    t_cell_cmd imm_cmd;
    t_cell_cmd int_cmd;
    t_entry    imm_ca [IMM_DEPTH+1];
    t_entry    imm_cb [IMM_DEPTH+1];
    t_entry    int_ca [INT_DEPTH+1];
    t_entry    int_cb [INT_DEPTH+1];
    t_entry    rd_a_data;
    t_entry    rd_b_data;

    always_comb begin
        imm_cmd       = cmd;
        imm_cmd.wr_en = cmd.wr_en & r_hsel;
        int_cmd       = cmd;
        int_cmd.wr_en = cmd.wr_en & ~r_hsel;
    end

    assign imm_ca[0] = '0;
    assign imm_cb[0] = '0;
    assign int_ca[0] = '0;
    assign int_cb[0] = '0;

    for (genvar k = 0; k < IMM_DEPTH; k++) begin : g_imm
        teh_cell u_cell (
            .i_clk     (i_clk),
            .i_idx     (IDX_W'(k)),
            .i_cmd     (imm_cmd),
            .i_chain_a (imm_ca[k]),
            .i_chain_b (imm_cb[k]),
            .o_chain_a (imm_ca[k+1]),
            .o_chain_b (imm_cb[k+1])
        );
    end

    for (genvar k = 0; k < INT_DEPTH; k++) begin : g_int
        teh_cell u_cell (
            .i_clk     (i_clk),
            .i_idx     (IDX_W'(k)),
            .i_cmd     (int_cmd),
            .i_chain_a (int_ca[k]),
            .i_chain_b (int_cb[k]),
            .o_chain_a (int_ca[k+1]),
            .o_chain_b (int_cb[k+1])
        );
    end

    assign rd_a_data = r_hsel ? imm_ca[IMM_DEPTH] : int_ca[INT_DEPTH];
    assign rd_b_data = r_hsel ? imm_cb[IMM_DEPTH] : int_cb[INT_DEPTH];

    // sequencer helpers
    logic [CNT_W-1:0]  par;
    logic [CNT_W:0]    a_idx;
    logic [CNT_W:0]    b_idx;
    logic [CNT_W:0]    n_ext;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] change;

    assign par    = (r_pos - CNT_W'(1)) >> 1;
    assign a_idx  = {r_pos, 1'b1};
    assign b_idx  = a_idx + (CNT_W+1)'(1);
    assign n_ext  = {1'b0, r_n};
    assign diff   = r_now - rd_a_data.tm;
    assign change = in_now - r_last_time;

    assign out_free = !r_out_v || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_hsel      = r_hsel;
        n_pos       = r_pos;
        n_n         = r_n;
        n_reb       = r_reb;
        n_cur       = r_cur;
        n_now       = r_now;
        n_idle      = r_idle;
        n_acc       = r_acc;
        n_imm_cnt   = r_imm_cnt;
        n_int_cnt   = r_int_cnt;
        n_last_time = r_last_time;
        n_pend_v    = r_pend_v;
        n_pend_hnd  = r_pend_hnd;
        n_pend_imm  = r_pend_imm;
        n_pend_late = r_pend_late;
        cmd         = '0;
        o_s_tready  = (r_state == ST_IDLE);
        out_load    = 1'b0;
        out_acc     = 1'b0;
        out_fired   = 1'b0;
        out_hnd     = '0;
        out_imm     = 1'b0;
        out_late    = '0;
        out_last    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_acc = 1'b0;
                    if (in_req == REQ_ADD) begin
                        n_hsel = in_imm;
                        n_cur  = {in_tm, in_hnd};
                        n_state = ST_DONE;
                        if (in_imm) begin
                            if (r_imm_cnt != CNT_W'(IMM_DEPTH)) begin
                                n_pos     = r_imm_cnt;
                                n_imm_cnt = r_imm_cnt + CNT_W'(1);
                                n_acc     = 1'b1;
                                n_state   = ST_INS;
                            end
                        end else begin
                            if (r_int_cnt != CNT_W'(INT_DEPTH)) begin
                                n_pos     = r_int_cnt;
                                n_int_cnt = r_int_cnt + CNT_W'(1);
                                n_acc     = 1'b1;
                                n_state   = ST_INS;
                            end
                        end
                    end else if (!r_enable || (change == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_now       = in_now;
                        n_idle      = in_idle;
                        n_last_time = in_now;
                        if ((in_now[31:28] == 4'd0) && (r_last_time[31:28] == 4'd11)) begin
                            cmd.clamp_en = 1'b1;
                            n_hsel  = 1'b0;
                            n_n     = r_int_cnt;
                            n_reb   = r_int_cnt >> 1;
                            n_state = ST_REB;
                        end else begin
                            if (change[TIME_W-1]) begin
                                cmd.sub_en = 1'b1;
                                cmd.amount = r_last_time - in_now;
                            end
                            n_hsel  = 1'b1;
                            n_state = ST_FIRE_IMM;
                        end
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_acc  = r_acc;
                    out_last = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            ST_INS: begin
                cmd.wr_en = 1'b1;
                cmd.rd_a  = par[IDX_W-1:0];
                if (r_pos == '0) begin
                    cmd.wr_idx  = '0;
                    cmd.wr_data = r_cur;
                    n_state     = ST_DONE;
                end else if (rd_a_data.tm > r_cur.tm) begin
                    cmd.wr_idx  = r_pos[IDX_W-1:0];
                    cmd.wr_data = rd_a_data;
                    n_pos       = par;
                end else begin
                    cmd.wr_idx  = r_pos[IDX_W-1:0];
                    cmd.wr_data = r_cur;
                    n_state     = ST_DONE;
                end
            end

            ST_REB: begin
                if (r_reb == '0) begin
                    if (!r_hsel) begin
                        n_hsel = 1'b1;
                        n_n    = r_imm_cnt;
                        n_reb  = r_imm_cnt >> 1;
                    end else begin
                        n_state = ST_FIRE_IMM;
                    end
                end else begin
                    n_reb   = r_reb - CNT_W'(1);
                    n_pos   = r_reb - CNT_W'(1);
                    n_ret   = ST_REB;
                    n_state = ST_LOAD;
                end
            end

            ST_LOAD: begin
                cmd.rd_a = r_pos[IDX_W-1:0];
                n_cur    = rd_a_data;
                n_state  = ST_SIFT;
            end

            ST_POP_LOAD: begin
                cmd.rd_a = r_n[IDX_W-1:0];
                n_cur    = rd_a_data;
                n_pos    = '0;
                n_state  = ST_SIFT;
            end

            ST_SIFT: begin
                cmd.rd_a   = a_idx[IDX_W-1:0];
                cmd.rd_b   = b_idx[IDX_W-1:0];
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = r_pos[IDX_W-1:0];
                cmd.wr_data = r_cur;
                priority if (a_idx >= n_ext) begin
                    n_state = r_ret;
                end else if (b_idx >= n_ext) begin
                    if (rd_a_data.tm < r_cur.tm) begin
                        cmd.wr_data = rd_a_data;
                        n_pos       = a_idx[CNT_W-1:0];
                    end else begin
                        n_state = r_ret;
                    end
                end else if ((rd_a_data.tm < r_cur.tm) && (rd_a_data.tm <= rd_b_data.tm)) begin
                    cmd.wr_data = rd_a_data;
                    n_pos       = a_idx[CNT_W-1:0];
                end else if (rd_b_data.tm < r_cur.tm) begin
                    cmd.wr_data = rd_b_data;
                    n_pos       = b_idx[CNT_W-1:0];
                end else begin
                    n_state = r_ret;
                end
            end

            ST_FIRE_IMM: begin
                cmd.rd_a = '0;
                if ((r_imm_cnt == '0) || diff[TIME_W-1]) begin
                    n_hsel  = 1'b0;
                    n_state = ST_FIRE_INT;
                end else if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        out_load  = 1'b1;
                        out_fired = 1'b1;
                        out_hnd   = r_pend_hnd;
                        out_imm   = r_pend_imm;
                        out_late  = r_pend_late;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_hnd  = rd_a_data.hnd;
                    n_pend_imm  = 1'b1;
                    n_pend_late = diff[LATE_W-1:0];
                    if (r_imm_cnt <= CNT_W'(1)) begin
                        n_imm_cnt = '0;
                    end else begin
                        n_imm_cnt = r_imm_cnt - CNT_W'(1);
                        n_n       = r_imm_cnt - CNT_W'(1);
                        n_ret     = ST_FIRE_IMM;
                        n_state   = ST_POP_LOAD;
                    end
                end
            end

            ST_FIRE_INT: begin
                cmd.rd_a = '0;
                if ((r_int_cnt != '0) && r_idle && !diff[TIME_W-1]) begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            out_load  = 1'b1;
                            out_fired = 1'b1;
                            out_hnd   = r_pend_hnd;
                            out_imm   = r_pend_imm;
                            out_late  = r_pend_late;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_hnd  = rd_a_data.hnd;
                        n_pend_imm  = 1'b0;
                        n_pend_late = diff[LATE_W-1:0];
                        if (r_int_cnt <= CNT_W'(1)) begin
                            n_int_cnt = '0;
                            n_state   = ST_END;
                        end else begin
                            n_int_cnt = r_int_cnt - CNT_W'(1);
                            n_n       = r_int_cnt - CNT_W'(1);
                            n_ret     = ST_END;
                            n_state   = ST_POP_LOAD;
                        end
                    end
                end else begin
                    n_state = ST_END;
                end
            end

            ST_END: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    if (r_pend_v) begin
                        out_fired = 1'b1;
                        out_hnd   = r_pend_hnd;
                        out_imm   = r_pend_imm;
                        out_late  = r_pend_late;
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_imm_cnt   <= '0;
            r_int_cnt   <= '0;
            r_last_time <= '0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_imm_cnt   <= n_imm_cnt;
            r_int_cnt   <= n_int_cnt;
            r_last_time <= n_last_time;
            r_pend_v    <= n_pend_v;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_hsel      <= n_hsel;
        r_pos       <= n_pos;
        r_n         <= n_n;
        r_reb       <= n_reb;
        r_cur       <= n_cur;
        r_now       <= n_now;
        r_idle      <= n_idle;
        r_acc       <= n_acc;
        r_pend_hnd  <= n_pend_hnd;
        r_pend_imm  <= n_pend_imm;
        r_pend_late <= n_pend_late;
        if (out_load) begin
            r_out_acc   <= out_acc;
            r_out_fired <= out_fired;
            r_out_hnd   <= out_hnd;
            r_out_imm   <= out_imm;
            r_out_late  <= out_late;
            r_out_last  <= out_last;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_W'(4 * REG_ENABLE))) begin
            r_enable <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_W'(4 * REG_ENABLE)) ? {31'd0, r_enable} : 32'd0;

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_fired;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(OUT_DATA_W - 49){1'b0}}, r_out_late, r_out_imm, r_out_hnd, r_out_acc};

    `TEH_ASSERT_ALWAYS(a_imm_cnt_bound, r_imm_cnt <= CNT_W'(IMM_DEPTH), "imm heap overfilled")
    `TEH_ASSERT_ALWAYS(a_int_cnt_bound, r_int_cnt <= CNT_W'(INT_DEPTH), "int heap overfilled")
    `TEH_ASSERT_IMPL(a_pend_in_tick, r_pend_v, r_state == ST_FIRE_IMM || r_state == ST_FIRE_INT || r_state == ST_POP_LOAD || r_state == ST_SIFT || r_state == ST_END, "pending fire outside tick")

endmodule

`default_nettype wire
